// ===== hw/rtl/barycentric_triangle_coverage_top_assert.svh =====
// Assertion macros used by the checker file.
`ifndef BARYCENTRIC_TRIANGLE_COVERAGE_TOP_ASSERT_SVH
`define BARYCENTRIC_TRIANGLE_COVERAGE_TOP_ASSERT_SVH
// Same-cycle implication, sampled on clk, off during reset.
`define BTC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("barycentric coverage check failed");
// Next-cycle implication, sampled on clk, off during reset.
`define BTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("barycentric coverage check failed");
`endif

// ===== hw/rtl/btc_pkg.sv =====
package btc_pkg;
  localparam int COORD_W  = 12;
  localparam int PIX_W    = 10;
  localparam int DIM_W    = 11;
  localparam int MAX_DIM  = 1024;
  localparam int FRAC_W   = 16;
  localparam int WGT_W    = FRAC_W + 3;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int CROSS_W  = PROD_W + 1;
  localparam int AREA_W   = CROSS_W + 3;
  localparam int MAG_W    = AREA_W - 1;
  localparam int Q_W      = FRAC_W + 2;
  localparam int DIV_W    = MAG_W + FRAC_W + 2;
  localparam int DIV_STEPS = Q_W;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  // Flags that ride along with one request through the divider.
  typedef struct packed {
    logic       covered;
    logic       degen;
    logic [2:0] neg;
    logic [2:0] sat;
  } ctl_t;

  // Divider state for the three weights (a, b, c).
  typedef struct packed {
    logic [2:0][DIV_W-1:0] rem;
    logic [2:0][MAG_W-1:0] den;
    logic [2:0][Q_W-1:0]   quo;
  } div_t;
endpackage

// ===== hw/rtl/btc_front.sv =====
module btc_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [btc_pkg::COORD_W-1:0] vertex_a_x,
  input  logic signed [btc_pkg::COORD_W-1:0] vertex_a_y,
  input  logic signed [btc_pkg::COORD_W-1:0] vertex_b_x,
  input  logic signed [btc_pkg::COORD_W-1:0] vertex_b_y,
  input  logic signed [btc_pkg::COORD_W-1:0] vertex_c_x,
  input  logic signed [btc_pkg::COORD_W-1:0] vertex_c_y,
  input  logic        [btc_pkg::PIX_W-1:0]   pixel_x,
  input  logic        [btc_pkg::PIX_W-1:0]   pixel_y,
  input  logic        [btc_pkg::PIX_W-1:0]   wlim,
  input  logic        [btc_pkg::PIX_W-1:0]   hlim,
  output logic                                v_out,
  output btc_pkg::ctl_t                       ctl_out,
  output btc_pkg::div_t                       div_out
);
  import btc_pkg::*;

  function automatic logic [PIX_W-1:0] clamp_pix(logic signed [COORD_W-1:0] m,
                                                 logic [PIX_W-1:0] lim);
    logic [PIX_W-1:0] r;
    if (m < 0) r = '0;
    else if (m > $signed({2'b00, lim})) r = lim;
    else r = m[PIX_W-1:0];
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] min3(logic signed [COORD_W-1:0] a,
                                                     logic signed [COORD_W-1:0] b,
                                                     logic signed [COORD_W-1:0] c);
    logic signed [COORD_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [COORD_W-1:0] max3(logic signed [COORD_W-1:0] a,
                                                     logic signed [COORD_W-1:0] b,
                                                     logic signed [COORD_W-1:0] c);
    logic signed [COORD_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic [MAG_W-1:0] mag(logic signed [AREA_W-1:0] v);
    logic [AREA_W-1:0] a;
    a = v[AREA_W-1] ? (~v + 1'b1) : v;
    return a[MAG_W-1:0];
  endfunction

  logic [4:0] v;

  // Stage 1: edge vectors and clamped bounding box.
  logic signed [DIFF_W-1:0] dxba, dyba, dxca, dyca, dxap, dyap;
  logic [PIX_W-1:0] lox, hix, loy, hiy, px1, py1;
  always_ff @(posedge clk) begin
    if (en) begin
      dxba <= {vertex_b_x[COORD_W-1], vertex_b_x} - {vertex_a_x[COORD_W-1], vertex_a_x};
      dyba <= {vertex_b_y[COORD_W-1], vertex_b_y} - {vertex_a_y[COORD_W-1], vertex_a_y};
      dxca <= {vertex_c_x[COORD_W-1], vertex_c_x} - {vertex_a_x[COORD_W-1], vertex_a_x};
      dyca <= {vertex_c_y[COORD_W-1], vertex_c_y} - {vertex_a_y[COORD_W-1], vertex_a_y};
      dxap <= {vertex_a_x[COORD_W-1], vertex_a_x} - {{(DIFF_W-PIX_W){1'b0}}, pixel_x};
      dyap <= {vertex_a_y[COORD_W-1], vertex_a_y} - {{(DIFF_W-PIX_W){1'b0}}, pixel_y};
      lox  <= clamp_pix(min3(vertex_a_x, vertex_b_x, vertex_c_x), wlim);
      hix  <= clamp_pix(max3(vertex_a_x, vertex_b_x, vertex_c_x), wlim);
      loy  <= clamp_pix(min3(vertex_a_y, vertex_b_y, vertex_c_y), hlim);
      hiy  <= clamp_pix(max3(vertex_a_y, vertex_b_y, vertex_c_y), hlim);
      px1  <= pixel_x;
      py1  <= pixel_y;
    end
  end

  // Stage 2: the six partial products and the box test.
  logic signed [PROD_W-1:0] p1, p2, p3, p4, p5, p6;
  logic inbox2;
  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= dxba * dyap;
      p2 <= dxap * dyba;
      p3 <= dxap * dyca;
      p4 <= dxca * dyap;
      p5 <= dxca * dyba;
      p6 <= dxba * dyca;
      inbox2 <= (px1 >= lox) && (px1 <= hix) && (py1 >= loy) && (py1 <= hiy);
    end
  end

  // Stage 3: cross product terms.
  logic signed [CROSS_W-1:0] ux3, uy3, uz3;
  logic inbox3;
  always_ff @(posedge clk) begin
    if (en) begin
      ux3 <= {p1[PROD_W-1], p1} - {p2[PROD_W-1], p2};
      uy3 <= {p3[PROD_W-1], p3} - {p4[PROD_W-1], p4};
      uz3 <= {p5[PROD_W-1], p5} - {p6[PROD_W-1], p6};
      inbox3 <= inbox2;
    end
  end

  // Stage 4: weight of the first vertex, sign test and degenerate flag.
  logic signed [AREA_W-1:0] ux_e, uy_e, uz_e, ua_c;
  logic signed [AREA_W-1:0] ux4, uy4, uz4, ua4;
  logic covered4, degen4;
  logic inside_c;
  always_comb begin
    ux_e = {{(AREA_W-CROSS_W){ux3[CROSS_W-1]}}, ux3};
    uy_e = {{(AREA_W-CROSS_W){uy3[CROSS_W-1]}}, uy3};
    uz_e = {{(AREA_W-CROSS_W){uz3[CROSS_W-1]}}, uz3};
    ua_c = uz_e - ux_e - uy_e;
    if (uz_e > 0) inside_c = (ua_c >= 0) && (uy_e >= 0) && (ux_e >= 0);
    else inside_c = (ua_c <= 0) && (uy_e <= 0) && (ux_e <= 0);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ux4 <= ux_e;
      uy4 <= uy_e;
      uz4 <= uz_e;
      ua4 <= ua_c;
      degen4 <= (uz_e == 0);
      covered4 <= inbox3 && inside_c && (uz_e != 0);
    end
  end

  // Stage 5: magnitudes, saturation, rounded dividend.
  logic [2:0][MAG_W-1:0] mn;
  logic [MAG_W-1:0] md;
  always_comb begin
    mn[0] = mag(ua4);
    mn[1] = mag(uy4);
    mn[2] = mag(ux4);
    md    = mag(uz4);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ctl_out.covered <= covered4;
      ctl_out.degen   <= degen4;
      ctl_out.neg     <= {ux4[AREA_W-1] ^ uz4[AREA_W-1], uy4[AREA_W-1] ^ uz4[AREA_W-1],
                          ua4[AREA_W-1] ^ uz4[AREA_W-1]};
      for (int k = 0; k < 3; k++) begin
        ctl_out.sat[k]  <= {1'b0, mn[k]} >= {md, 1'b0};
        div_out.rem[k]  <= ({{(DIV_W-MAG_W){1'b0}}, mn[k]} << FRAC_W)
                           + {{(DIV_W-MAG_W+1){1'b0}}, md[MAG_W-1:1]};
        div_out.den[k]  <= md;
        div_out.quo[k]  <= '0;
      end
    end
  end

  // Valid bits for the five stages.
  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else if (en) v <= {v[3:0], in_valid};
  end
  assign v_out = v[4];
endmodule

// ===== hw/rtl/btc_div_step.sv =====
module btc_div_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          v_in,
  input  btc_pkg::ctl_t ctl_in,
  input  btc_pkg::div_t div_in,
  output logic          v_out,
  output btc_pkg::ctl_t ctl_out,
  output btc_pkg::div_t div_out
);
  import btc_pkg::*;

  // One restoring step per weight: compare against the divisor at the top
  // quotient position, subtract if it fits, then shift the remainder up.
  logic [2:0][DIV_W-1:0] dsh, rnew;
  logic [2:0] bitq;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dsh[k]  = {{(DIV_W-MAG_W){1'b0}}, div_in.den[k]} << (Q_W - 1);
      bitq[k] = div_in.rem[k] >= dsh[k];
      rnew[k] = bitq[k] ? (div_in.rem[k] - dsh[k]) : div_in.rem[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_out <= ctl_in;
      for (int k = 0; k < 3; k++) begin
        div_out.rem[k] <= {rnew[k][DIV_W-2:0], 1'b0};
        div_out.den[k] <= div_in.den[k];
        div_out.quo[k] <= {div_in.quo[k][Q_W-2:0], bitq[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v_out <= 1'b0;
    else if (en) v_out <= v_in;
  end
endmodule

// ===== hw/rtl/barycentric_triangle_coverage_top.sv =====
// Barycentric coverage test, one triangle and one pixel per request.
// Input channel: in_valid / in_stall with the six vertex coordinates and the
// pixel. Output channel: out_valid / out_stall with covered, degenerate and
// the three weights (signed, 16 fraction bits, saturated at 2.0).
// A request is taken on a clock edge where valid is high and stall is low.
// Throughput is one request per cycle while the output is not stalled.
// Between acceptance and out_valid a request passes five setup stages (edge
// vectors and box, products, cross terms, sign test, magnitudes), 18
// restoring divider stages, one for a quotient bit each, and the output
// register that applies sign, saturation and the degenerate value.
// While the receiver stalls a valid result, the whole pipeline holds in
// place and in_stall is raised in the same cycle; nothing is dropped or
// repeated. A stall delays every request in flight for as long as it lasts.
// The configuration port writes image_width (index 0) or image_height
// (index 1); other indexes are ignored. Write only while idle.
// Synchronous reset empties the pipeline and sets both sizes to 800.
module barycentric_triangle_coverage_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [btc_pkg::COORD_W-1:0] vertex_a_x,
  input  logic signed [btc_pkg::COORD_W-1:0] vertex_a_y,
  input  logic signed [btc_pkg::COORD_W-1:0] vertex_b_x,
  input  logic signed [btc_pkg::COORD_W-1:0] vertex_b_y,
  input  logic signed [btc_pkg::COORD_W-1:0] vertex_c_x,
  input  logic signed [btc_pkg::COORD_W-1:0] vertex_c_y,
  input  logic        [btc_pkg::PIX_W-1:0]   pixel_x,
  input  logic        [btc_pkg::PIX_W-1:0]   pixel_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                covered,
  output logic                                degenerate,
  output logic signed [btc_pkg::WGT_W-1:0]   weight_a,
  output logic signed [btc_pkg::WGT_W-1:0]   weight_b,
  output logic signed [btc_pkg::WGT_W-1:0]   weight_c,
  input  logic                                cfg_we,
  input  logic        [1:0]                   cfg_index,
  input  logic        [btc_pkg::DIM_W-1:0]   cfg_data
);
  import btc_pkg::*;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(800);
  localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(MAX_DIM);

  // Configuration registers.
  logic [DIM_W-1:0] image_width, image_height;
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_RESET;
      image_height <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Largest pixel index on each axis.
  function automatic logic [PIX_W-1:0] dim_lim(logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) r = '0;
    else if (d > DIM_MAX) r = DIM_MAX - 1'b1;
    else r = d - 1'b1;
    return r[PIX_W-1:0];
  endfunction

  logic [PIX_W-1:0] wlim, hlim;
  assign wlim = dim_lim(image_width);
  assign hlim = dim_lim(image_height);

  // Whole pipeline moves unless the output holds a stalled result.
  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  logic [DIV_STEPS:0] vd;
  ctl_t ctl_d [DIV_STEPS+1];
  div_t div_d [DIV_STEPS+1];

  btc_front u_front (
    .clk, .rst, .en, .in_valid,
    .vertex_a_x, .vertex_a_y, .vertex_b_x, .vertex_b_y, .vertex_c_x, .vertex_c_y,
    .pixel_x, .pixel_y, .wlim, .hlim,
    .v_out(vd[0]), .ctl_out(ctl_d[0]), .div_out(div_d[0])
  );

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    btc_div_step u_step (
      .clk, .rst, .en,
      .v_in(vd[s]), .ctl_in(ctl_d[s]), .div_in(div_d[s]),
      .v_out(vd[s+1]), .ctl_out(ctl_d[s+1]), .div_out(div_d[s+1])
    );
  end

  // Final weight: degenerate value, saturation, then sign.
  function automatic logic [WGT_W-1:0] fin(logic neg, logic sat, logic [Q_W-1:0] q);
    logic [WGT_W-1:0] m;
    m = sat ? (WGT_W'(1) << (FRAC_W + 1)) : {{(WGT_W-Q_W){1'b0}}, q};
    return neg ? (~m + 1'b1) : m;
  endfunction

  localparam logic [WGT_W-1:0] NEG_ONE = ~(WGT_W'(1) << FRAC_W) + 1'b1;

  logic [2:0][WGT_W-1:0] w;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      w[k] = ctl_d[DIV_STEPS].degen ? NEG_ONE
           : fin(ctl_d[DIV_STEPS].neg[k], ctl_d[DIV_STEPS].sat[k], div_d[DIV_STEPS].quo[k]);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      covered    <= ctl_d[DIV_STEPS].covered;
      degenerate <= ctl_d[DIV_STEPS].degen;
      weight_a   <= w[0];
      weight_b   <= w[1];
      weight_c   <= w[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vd[DIV_STEPS];
  end
endmodule

// ===== hw/rtl/btc_checker.sv =====
`include "barycentric_triangle_coverage_top_assert.svh"
module btc_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                covered,
  input logic                                degenerate,
  input logic signed [btc_pkg::WGT_W-1:0]   weight_a,
  input logic signed [btc_pkg::WGT_W-1:0]   weight_b,
  input logic signed [btc_pkg::WGT_W-1:0]   weight_c
);
  import btc_pkg::*;

  localparam logic signed [WGT_W-1:0] NEG_ONE = -(WGT_W'(1) << FRAC_W);

  // A stalled result stays offered.
  `BTC_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid)
  // Input is held off exactly while a result is stalled.
  `BTC_ASSERT_NOW(a_backpressure, 1'b1, in_stall == (out_valid && out_stall))
  // A degenerate triangle covers nothing and reports minus one.
  `BTC_ASSERT_NOW(a_degen, out_valid && degenerate,
                  !covered && weight_a == NEG_ONE && weight_b == NEG_ONE && weight_c == NEG_ONE)
  // A covered pixel has no negative weight.
  `BTC_ASSERT_NOW(a_cover, out_valid && covered,
                  !weight_a[WGT_W-1] && !weight_b[WGT_W-1] && !weight_c[WGT_W-1])
endmodule

bind barycentric_triangle_coverage_top btc_checker u_btc_checker (.*);
